### rtl/hrht_pkg.sv
// ----------------------------------------------------------------------------
// hrht_pkg
// Types, codes and helper functions shared by the request head tokenizer.
// ----------------------------------------------------------------------------
package hrht_pkg;

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_URL,
      PH_PROTO,
      PH_LINE,
      PH_NAME,
      PH_VALUE,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_HIGH,
      ESC_LOW,
      ESC_LOW_BAD
   } esc_type;

   localparam logic [2:0] KIND_METHOD   = 3'd0;
   localparam logic [2:0] KIND_URL      = 3'd1;
   localparam logic [2:0] KIND_PROTOCOL = 3'd2;
   localparam logic [2:0] KIND_NAME     = 3'd3;
   localparam logic [2:0] KIND_VALUE    = 3'd4;

   localparam logic [1:0] STATUS_RUN      = 2'd0;
   localparam logic [1:0] STATUS_DONE     = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;
   localparam logic [1:0] STATUS_BAD_EOL  = 2'd3;

   localparam logic [1:0] CSR_METHOD_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_URL_LIMIT      = 2'd1;
   localparam logic [1:0] CSR_PROTOCOL_LIMIT = 2'd2;
   localparam logic [1:0] CSR_FIELD_LIMIT    = 2'd3;

   localparam logic [9:0] METHOD_LIMIT_RST   = 10'd100;
   localparam logic [9:0] URL_LIMIT_RST      = 10'd1000;
   localparam logic [9:0] PROTOCOL_LIMIT_RST = 10'd50;
   localparam logic [9:0] FIELD_LIMIT_RST    = 10'd1000;

   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_SP      = 8'h20;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   typedef struct packed {
      logic [9:0] method_limit;
      logic [9:0] url_limit;
      logic [9:0] protocol_limit;
      logic [9:0] field_limit;
   } limits_type;

   typedef struct packed {
      phase_type  phase;
      logic       cr_seen;
      logic [9:0] byte_count;
      esc_type    escape_step;
      logic [3:0] escape_high;
      logic       value_started;
   } state_type;

   typedef struct packed {
      logic       has_result;
      logic [2:0] token_kind;
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       token_end;
      logic [1:0] status;
      logic       bad_escape;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.val = b[3:0];
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         h.val = b[3:0] + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [2:0] kind_of(input phase_type p);
      logic [2:0] k;
      k = KIND_NAME;
      if (p == PH_METHOD) begin
         k = KIND_METHOD;
      end else if (p == PH_URL) begin
         k = KIND_URL;
      end else if (p == PH_PROTO) begin
         k = KIND_PROTOCOL;
      end else if (p == PH_VALUE) begin
         k = KIND_VALUE;
      end
      return k;
   endfunction

   localparam state_type STATE_RST = '{
      phase:         PH_METHOD,
      cr_seen:       1'b0,
      byte_count:    10'd0,
      escape_step:   ESC_NONE,
      escape_high:   4'd0,
      value_started: 1'b0
   };

endpackage

### rtl/hrht_csr.sv
// ----------------------------------------------------------------------------
// hrht_csr
// Token length limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module hrht_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_wdata,
   output hrht_pkg::limits_type limits
);
   import hrht_pkg::*;

   limits_type limits_ff;
   limits_type limits_in;

   always_comb begin
      limits_in = limits_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_METHOD_LIMIT:   limits_in.method_limit   = csr_wdata;
            CSR_URL_LIMIT:      limits_in.url_limit      = csr_wdata;
            CSR_PROTOCOL_LIMIT: limits_in.protocol_limit = csr_wdata;
            CSR_FIELD_LIMIT:    limits_in.field_limit    = csr_wdata;
            default:            limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.method_limit   <= METHOD_LIMIT_RST;
         limits_ff.url_limit      <= URL_LIMIT_RST;
         limits_ff.protocol_limit <= PROTOCOL_LIMIT_RST;
         limits_ff.field_limit    <= FIELD_LIMIT_RST;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

### rtl/hrht_step.sv
// ----------------------------------------------------------------------------
// hrht_step
// Per-byte tokenizer logic: next phase state and the result for one byte.
// ----------------------------------------------------------------------------
module hrht_step (
   input  hrht_pkg::state_type  cur,
   input  hrht_pkg::limits_type lim,
   input  logic [7:0]           in_byte,
   output hrht_pkg::state_type  nxt,
   output hrht_pkg::result_type res
);
   import hrht_pkg::*;

   logic [9:0] name_count;
   hex_type    hx;

   always_comb begin
      nxt        = cur;
      res        = '0;
      name_count = (cur.phase == PH_LINE) ? 10'd0 : cur.byte_count;
      hx         = hex_decode(in_byte);
      unique case (cur.phase) inside
         PH_METHOD: begin
            if (in_byte == CHAR_SP) begin
               nxt.phase       = PH_URL;
               nxt.byte_count  = 10'd0;
               nxt.escape_step = ESC_NONE;
               res.has_result  = 1'b1;
               res.token_kind  = KIND_METHOD;
               res.token_end   = 1'b1;
            end else if (cur.byte_count >= lim.method_limit) begin
               nxt.phase      = PH_FAIL;
               nxt.cr_seen    = 1'b0;
               res.has_result = 1'b1;
               res.token_kind = KIND_METHOD;
               res.status     = STATUS_TOO_LONG;
            end else begin
               nxt.byte_count = cur.byte_count + 10'd1;
               res.has_result = 1'b1;
               res.token_kind = KIND_METHOD;
               res.out_byte   = in_byte;
               res.byte_valid = 1'b1;
            end
         end
         PH_URL: begin
            if (in_byte == CHAR_SP) begin
               nxt.phase       = PH_PROTO;
               nxt.byte_count  = 10'd0;
               nxt.cr_seen     = 1'b0;
               nxt.escape_step = ESC_NONE;
               res.has_result  = 1'b1;
               res.token_kind  = KIND_URL;
               res.token_end   = 1'b1;
               res.bad_escape  = (cur.escape_step != ESC_NONE);
            end else if (cur.byte_count >= lim.url_limit) begin
               nxt.phase      = PH_FAIL;
               nxt.cr_seen    = 1'b0;
               res.has_result = 1'b1;
               res.token_kind = KIND_URL;
               res.status     = STATUS_TOO_LONG;
            end else begin
               nxt.byte_count = cur.byte_count + 10'd1;
               case (cur.escape_step)
                  ESC_NONE: begin
                     if (in_byte == CHAR_PERCENT) begin
                        nxt.escape_step = ESC_HIGH;
                     end else begin
                        res.has_result = 1'b1;
                        res.token_kind = KIND_URL;
                        res.out_byte   = in_byte;
                        res.byte_valid = 1'b1;
                     end
                  end
                  ESC_HIGH: begin
                     nxt.escape_high = hx.ok ? hx.val : in_byte[3:0];
                     nxt.escape_step = hx.ok ? ESC_LOW : ESC_LOW_BAD;
                  end
                  default: begin
                     nxt.escape_step = ESC_NONE;
                     res.has_result  = 1'b1;
                     res.token_kind  = KIND_URL;
                     res.out_byte    = {cur.escape_high, 4'd0}
                                       + (hx.ok ? {4'd0, hx.val} : in_byte);
                     res.byte_valid  = 1'b1;
                     res.bad_escape  = (cur.escape_step == ESC_LOW_BAD) || !hx.ok;
                  end
               endcase
            end
         end
         PH_PROTO: begin
            if (in_byte == CHAR_CR) begin
               nxt.cr_seen = 1'b1;
            end else if (in_byte == CHAR_LF && cur.cr_seen) begin
               nxt.cr_seen    = 1'b0;
               nxt.phase      = PH_LINE;
               nxt.byte_count = 10'd0;
               res.has_result = 1'b1;
               res.token_kind = KIND_PROTOCOL;
               res.token_end  = 1'b1;
            end else if (cur.byte_count >= lim.protocol_limit) begin
               nxt.phase      = PH_FAIL;
               nxt.cr_seen    = 1'b0;
               res.has_result = 1'b1;
               res.token_kind = KIND_PROTOCOL;
               res.status     = STATUS_TOO_LONG;
            end else begin
               nxt.cr_seen    = 1'b0;
               nxt.byte_count = cur.byte_count + 10'd1;
               res.has_result = 1'b1;
               res.token_kind = KIND_PROTOCOL;
               res.out_byte   = in_byte;
               res.byte_valid = 1'b1;
            end
         end
         PH_LINE, PH_NAME: begin
            if (cur.phase == PH_LINE && cur.cr_seen) begin
               nxt.cr_seen    = 1'b0;
               res.has_result = 1'b1;
               res.token_kind = KIND_NAME;
               if (in_byte == CHAR_LF) begin
                  nxt.phase  = PH_DONE;
                  res.status = STATUS_DONE;
               end else begin
                  nxt.phase  = PH_FAIL;
                  res.status = STATUS_BAD_EOL;
               end
            end else if (cur.phase == PH_LINE && in_byte == CHAR_CR) begin
               nxt.cr_seen = 1'b1;
            end else if (cur.phase == PH_LINE && in_byte == CHAR_SP) begin
               // one leading space on a header line is skipped
               nxt.phase      = PH_NAME;
               nxt.byte_count = 10'd0;
            end else if (in_byte == CHAR_COLON) begin
               nxt.phase         = PH_VALUE;
               nxt.byte_count    = 10'd0;
               nxt.value_started = 1'b0;
               nxt.cr_seen       = 1'b0;
               res.has_result    = 1'b1;
               res.token_kind    = KIND_NAME;
               res.token_end     = 1'b1;
            end else if (name_count >= lim.field_limit) begin
               nxt.phase      = PH_FAIL;
               nxt.cr_seen    = 1'b0;
               res.has_result = 1'b1;
               res.token_kind = KIND_NAME;
               res.status     = STATUS_TOO_LONG;
            end else begin
               nxt.phase      = PH_NAME;
               nxt.byte_count = name_count + 10'd1;
               res.has_result = 1'b1;
               res.token_kind = KIND_NAME;
               res.out_byte   = in_byte;
               res.byte_valid = 1'b1;
            end
         end
         PH_VALUE: begin
            if (in_byte == CHAR_CR) begin
               nxt.cr_seen = 1'b1;
            end else if (in_byte == CHAR_LF && cur.cr_seen) begin
               nxt.cr_seen       = 1'b0;
               nxt.phase         = PH_LINE;
               nxt.byte_count    = 10'd0;
               nxt.value_started = 1'b0;
               res.has_result    = 1'b1;
               res.token_kind    = KIND_VALUE;
               res.token_end     = 1'b1;
            end else if (cur.byte_count >= lim.field_limit) begin
               nxt.phase      = PH_FAIL;
               nxt.cr_seen    = 1'b0;
               res.has_result = 1'b1;
               res.token_kind = kind_of(cur.phase);
               res.status     = STATUS_TOO_LONG;
            end else begin
               nxt.cr_seen    = 1'b0;
               nxt.byte_count = cur.byte_count + 10'd1;
               if (!cur.value_started) begin
                  // first value byte is dropped
                  nxt.value_started = 1'b1;
               end else begin
                  res.has_result = 1'b1;
                  res.token_kind = KIND_VALUE;
                  res.out_byte   = in_byte;
                  res.byte_valid = 1'b1;
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

### rtl/hrht_out.sv
// ----------------------------------------------------------------------------
// hrht_out
// Result register driving the response stream.
// ----------------------------------------------------------------------------
module hrht_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hrht_pkg::result_type res,
   output logic                 can_take,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   output logic [3:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import hrht_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign can_take = !valid_ff || rsp_tready;

   always_comb begin
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, res_ff.bad_escape, res_ff.status, res_ff.out_byte};
   assign rsp_tuser  = {res_ff.byte_valid, res_ff.token_kind};
   assign rsp_tlast  = res_ff.token_end;

endmodule

### rtl/http_request_head_tokenizer.sv
// ----------------------------------------------------------------------------
// http_request_head_tokenizer
// Splits an HTTP request head into tagged token bytes, end marks and status results.
// ----------------------------------------------------------------------------
// path: input register, combinational phase update, result register, response side
// throughput: one byte per cycle, set by the phase update, while results are taken
// a byte that yields no result still takes one slot in the input register
// reset: phase state returns to method, limits return to 100/1000/50/1000,
// both pipeline registers empty
module http_request_head_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [9:8] status, [10] bad_escape
   output logic [3:0]  rsp_tuser,   // [2:0] token_kind, [3] byte_valid
   output logic        rsp_tlast,   // token_end
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   import hrht_pkg::*;

   limits_type limits;
   state_type  state_ff;
   state_type  state_in;
   state_type  state_nxt;
   result_type res;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       can_take;
   logic       advance;
   logic       push;

   hrht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   hrht_step u_step (
      .cur     (state_ff),
      .lim     (limits),
      .in_byte (in_byte_ff),
      .nxt     (state_nxt),
      .res     (res)
   );

   assign advance    = in_valid_ff && (!res.has_result || can_take);
   assign push       = advance && res.has_result;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      state_in = advance ? state_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RST;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   hrht_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .res        (res),
      .can_take   (can_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/hrht_checker.sv
// ----------------------------------------------------------------------------
// hrht_checker
// Port-level checks on the tokenizer response stream.
// ----------------------------------------------------------------------------
module hrht_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import hrht_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // nothing on the response side right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a token byte never carries an end mark
   a_byte_or_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[3] && rsp_tlast))
      else $error("byte and end mark together");

   // final status results carry no byte and no end mark
   a_status_bare: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9:8] != STATUS_RUN |-> !rsp_tuser[3] && !rsp_tlast)
      else $error("status result with payload");

   // escape errors only on url tokens
   a_escape_url: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tuser[2:0] == KIND_URL)
      else $error("bad escape outside url");

endmodule

bind http_request_head_tokenizer hrht_checker u_checker (.*);

### sim/http_request_head_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// http_request_head_tokenizer_tb
// Feeds one long request head through the tokenizer and checks every token
// transaction against a cycle-free model of the tokenizer. The head starts
// with short directed parts, then goes on with random header lines under
// changing limits and closes with a blank line, an overlong token or a
// broken line end, then trailing bytes that must be ignored.
// ----------------------------------------------------------------------------
module http_request_head_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hrht_pkg::*;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       valid;
      logic       last;
      logic [1:0] status;
      logic       bad;
   } token_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_METHOD_LIMIT;
   logic [9:0]  csr_wdata = '0;

   logic [7:0] head_bytes[$];
   token_type  token_q[$];
   token_type  got, want;
   bit         idle_on = 1'b1;
   int         gap_left = 0;
   int         stall_left = 0;
   int         n_bytes = 0;
   int         n_lines = 0;
   int         n_checked = 0;
   int         errors = 0;
   string      end_kind;

   logic [9:0] method_lim = METHOD_LIMIT_RST;
   logic [9:0] url_lim    = URL_LIMIT_RST;
   logic [9:0] proto_lim  = PROTOCOL_LIMIT_RST;
   logic [9:0] field_lim  = FIELD_LIMIT_RST;

   phase_type  ph = PH_METHOD;
   logic       cr = 1'b0;
   logic [9:0] count = '0;
   esc_type    esc = ESC_NONE;
   logic [3:0] esc_hi = '0;
   logic       val_started = 1'b0;

   http_request_head_tokenizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) begin
         return {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         return {1'b1, c[3:0] + 4'd9};
      end
      return 5'b0;
   endfunction

   function automatic logic [2:0] kind_for(input phase_type p);
      case (p)
         PH_METHOD: return KIND_METHOD;
         PH_URL:    return KIND_URL;
         PH_PROTO:  return KIND_PROTOCOL;
         PH_VALUE:  return KIND_VALUE;
         default:   return KIND_NAME;
      endcase
   endfunction

   task automatic put_token(input logic [2:0] kind, input logic [7:0] data,
                            input logic valid, input logic last,
                            input logic [1:0] status, input logic bad);
      token_type t;
      t = '{kind: kind, data: data, valid: valid, last: last,
            status: status, bad: bad};
      token_q.insert(token_q.size(), t);
   endtask

   task automatic abort(input logic [1:0] status);
      logic [2:0] kind;
      kind = kind_for(ph);
      ph = PH_FAIL;
      cr = 1'b0;
      put_token(kind, 8'h00, 1'b0, 1'b0, status, 1'b0);
   endtask

   task automatic name_char(input logic [7:0] b);
      if (b == CHAR_COLON) begin
         ph = PH_VALUE;
         count = '0;
         val_started = 1'b0;
         cr = 1'b0;
         put_token(KIND_NAME, 8'h00, 1'b0, 1'b1, STATUS_RUN, 1'b0);
      end else if (count >= field_lim) begin
         abort(STATUS_TOO_LONG);
      end else begin
         count++;
         put_token(KIND_NAME, b, 1'b1, 1'b0, STATUS_RUN, 1'b0);
      end
   endtask

   task automatic tokenize(input logic [7:0] b);
      logic [4:0] hx;
      logic       bad;
      logic [7:0] low;
      hx = hex_value(b);
      case (ph)
         PH_METHOD: begin
            if (b == CHAR_SP) begin
               ph = PH_URL;
               count = '0;
               esc = ESC_NONE;
               put_token(KIND_METHOD, 8'h00, 1'b0, 1'b1, STATUS_RUN, 1'b0);
            end else if (count >= method_lim) begin
               abort(STATUS_TOO_LONG);
            end else begin
               count++;
               put_token(KIND_METHOD, b, 1'b1, 1'b0, STATUS_RUN, 1'b0);
            end
         end
         PH_URL: begin
            if (b == CHAR_SP) begin
               bad = (esc != ESC_NONE);
               esc = ESC_NONE;
               ph = PH_PROTO;
               count = '0;
               cr = 1'b0;
               put_token(KIND_URL, 8'h00, 1'b0, 1'b1, STATUS_RUN, bad);
            end else if (count >= url_lim) begin
               abort(STATUS_TOO_LONG);
            end else begin
               count++;
               case (esc)
                  ESC_NONE: begin
                     if (b == CHAR_PERCENT) begin
                        esc = ESC_HIGH;
                     end else begin
                        put_token(KIND_URL, b, 1'b1, 1'b0, STATUS_RUN, 1'b0);
                     end
                  end
                  ESC_HIGH: begin
                     if (hx[4]) begin
                        esc_hi = hx[3:0];
                        esc = ESC_LOW;
                     end else begin
                        esc_hi = b[3:0];
                        esc = ESC_LOW_BAD;
                     end
                  end
                  default: begin
                     bad = (esc == ESC_LOW_BAD) || !hx[4];
                     low = hx[4] ? {4'h0, hx[3:0]} : b;
                     esc = ESC_NONE;
                     put_token(KIND_URL, {esc_hi, 4'h0} + low, 1'b1, 1'b0,
                               STATUS_RUN, bad);
                  end
               endcase
            end
         end
         PH_PROTO: begin
            if (b == CHAR_CR) begin
               cr = 1'b1;
            end else if (b == CHAR_LF && cr) begin
               cr = 1'b0;
               ph = PH_LINE;
               count = '0;
               put_token(KIND_PROTOCOL, 8'h00, 1'b0, 1'b1, STATUS_RUN, 1'b0);
            end else begin
               cr = 1'b0;
               if (count >= proto_lim) begin
                  abort(STATUS_TOO_LONG);
               end else begin
                  count++;
                  put_token(KIND_PROTOCOL, b, 1'b1, 1'b0, STATUS_RUN, 1'b0);
               end
            end
         end
         PH_LINE: begin
            if (cr) begin
               cr = 1'b0;
               if (b == CHAR_LF) begin
                  ph = PH_DONE;
                  put_token(KIND_NAME, 8'h00, 1'b0, 1'b0, STATUS_DONE, 1'b0);
               end else begin
                  abort(STATUS_BAD_EOL);
               end
            end else if (b == CHAR_CR) begin
               cr = 1'b1;
            end else begin
               ph = PH_NAME;
               count = '0;
               if (b != CHAR_SP) begin
                  name_char(b);
               end
            end
         end
         PH_NAME: begin
            name_char(b);
         end
         PH_VALUE: begin
            if (b == CHAR_CR) begin
               cr = 1'b1;
            end else if (b == CHAR_LF && cr) begin
               cr = 1'b0;
               ph = PH_LINE;
               count = '0;
               val_started = 1'b0;
               put_token(KIND_VALUE, 8'h00, 1'b0, 1'b1, STATUS_RUN, 1'b0);
            end else begin
               cr = 1'b0;
               if (count >= field_lim) begin
                  abort(STATUS_TOO_LONG);
               end else begin
                  count++;
                  if (!val_started) begin
                     val_started = 1'b1;
                  end else begin
                     put_token(KIND_VALUE, b, 1'b1, 1'b0, STATUS_RUN, 1'b0);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tokenize(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (head_bytes.size() != 0 && idle_on && $urandom_range(0, 4) == 0) begin
               gap_left <= $urandom_range(0, 2);
               req_tvalid <= 1'b0;
            end else if (head_bytes.size() != 0) begin
               req_tdata <= head_bytes.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{kind: rsp_tuser[2:0], data: rsp_tdata[7:0], valid: rsp_tuser[3],
                    last: rsp_tlast, status: rsp_tdata[9:8], bad: rsp_tdata[10]};
            n_checked++;
            if (token_q.size() == 0) begin
               errors++;
               $display("%0t: token with none expected", $time);
               $display("   expected none");
               $display("   actual   kind %0d byte %02h valid %0b end %0b status %0d bad %0b",
                        got.kind, got.data, got.valid, got.last, got.status, got.bad);
            end else begin
               want = token_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: token mismatch", $time);
                  $display("   expected kind %0d byte %02h valid %0b end %0b status %0d bad %0b",
                           want.kind, want.data, want.valid, want.last, want.status,
                           want.bad);
                  $display("   actual   kind %0d byte %02h valid %0b end %0b status %0d bad %0b",
                           got.kind, got.data, got.valid, got.last, got.status, got.bad);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_byte(input logic [7:0] b);
      head_bytes.insert(head_bytes.size(), b);
      n_bytes++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i]);
      end
   endtask

   task automatic wait_idle();
      while (head_bytes.size() != 0 || req_tvalid || token_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [1:0] idx, input logic [9:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_METHOD_LIMIT:   method_lim = val;
         CSR_URL_LIMIT:      url_lim = val;
         CSR_PROTOCOL_LIMIT: proto_lim = val;
         default:            field_lim = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] escape_digit();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0: begin
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_SP);
         end
         1, 2, 3: b = 8'h30 + 8'($urandom_range(0, 9));
         4, 5:    b = 8'h41 + 8'($urandom_range(0, 5));
         default: b = 8'h61 + 8'($urandom_range(0, 5));
      endcase
      return b;
   endfunction

   task automatic send_url(input int budget);
      int         used;
      logic [7:0] b;
      used = 0;
      while (used < budget) begin
         if (budget - used >= 3 && $urandom_range(0, 4) == 0) begin
            push_byte(CHAR_PERCENT);
            push_byte(escape_digit());
            push_byte(escape_digit());
            used += 3;
         end else begin
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_SP || b == CHAR_PERCENT);
            push_byte(b);
            used++;
         end
      end
      // partial escape cut off by the space
      if ($urandom_range(0, 1) == 1) begin
         push_byte(CHAR_PERCENT);
         if ($urandom_range(0, 1) == 1) begin
            push_byte(escape_digit());
         end
      end
      push_byte(CHAR_SP);
   endtask

   function automatic int pick_len(input int limit);
      int cap;
      cap = (limit < 24) ? limit : 24;
      case ($urandom_range(0, 7))
         0: return 0;
         1: return (limit <= 64) ? limit : $urandom_range(64, (limit < 200) ? limit : 200);
         default: return (cap == 0) ? 0 : $urandom_range(1, cap);
      endcase
   endfunction

   task automatic send_name(input int len, input bit lead);
      logic [7:0] b;
      if (lead) begin
         push_byte(CHAR_SP);
      end
      for (int i = 0; i < len; i++) begin
         do b = 8'($urandom_range(0, 255));
         while (b == CHAR_COLON || (i == 0 && !lead && (b == CHAR_CR || b == CHAR_SP)));
         push_byte(b);
      end
      push_byte(CHAR_COLON);
   endtask

   task automatic send_value(input int len);
      logic [7:0] b;
      bit         after_cr;
      after_cr = 1'b0;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            push_byte(CHAR_CR);
            after_cr = 1'b1;
         end
         do b = 8'($urandom_range(0, 255));
         while (b == CHAR_CR || (after_cr && b == CHAR_LF));
         push_byte(b);
         after_cr = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
         push_byte(CHAR_CR);
      end
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
   endtask

   task automatic send_line();
      send_name(pick_len(int'(field_lim)), $urandom_range(0, 3) == 0);
      send_value(pick_len(int'(field_lim)));
      n_lines++;
   endtask

   initial begin
      int lim;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // method, URL and protocol with limits raised mid-token
      write_limit(CSR_METHOD_LIMIT, 10'd1);
      push_byte(8'h00);
      wait_idle();
      write_limit(CSR_METHOD_LIMIT, 10'd1023);
      push_byte(8'hFF);
      push_byte(CHAR_COLON);
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      push_byte(CHAR_SP);
      wait_idle();
      write_limit(CSR_URL_LIMIT, 10'd1);
      push_byte(CHAR_PERCENT);
      wait_idle();
      write_limit(CSR_URL_LIMIT, 10'd1023);
      push_text("41%6f%zG%4z");
      send_url($urandom_range(150, 400));
      wait_idle();
      write_limit(CSR_PROTOCOL_LIMIT, 10'd1);
      push_byte(8'h48);
      wait_idle();
      write_limit(CSR_PROTOCOL_LIMIT, 10'd3);
      push_byte(8'h54);
      push_byte(CHAR_CR);
      push_byte(8'h50);
      push_byte(CHAR_CR);
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      wait_idle();

      // header lines under changing field limits
      while (n_bytes < 1500) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 4))
            0: lim = 1;
            1: lim = 1023;
            2: lim = $urandom_range(2, 8);
            3: lim = $urandom_range(9, 64);
            default: lim = $urandom_range(1, 1023);
         endcase
         write_limit(CSR_FIELD_LIMIT, 10'(lim));
         if ($urandom_range(0, 3) == 0) begin
            write_limit(2'($urandom_range(CSR_METHOD_LIMIT, CSR_PROTOCOL_LIMIT)),
                        10'($urandom_range(0, 1023)));
         end
         repeat ($urandom_range(2, 8)) send_line();
         wait_idle();
      end

      // closing part without idling
      idle_on = 1'b0;
      repeat ($urandom_range(2, 4)) send_line();
      wait_idle();
      case ($urandom_range(0, 2))
         0: begin
            end_kind = "blank line";
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
         end
         1: begin
            end_kind = "overlong header token";
            lim = $urandom_range(0, 4);
            write_limit(CSR_FIELD_LIMIT, 10'(lim));
            if ($urandom_range(0, 1) == 1) begin
               send_name(lim + 1, $urandom_range(0, 1) == 1);
            end else begin
               send_name($urandom_range(0, lim), 1'b0);
               send_value(lim + 1);
            end
         end
         default: begin
            end_kind = "CR without LF at line start";
            push_byte(CHAR_CR);
            push_byte(($urandom_range(0, 1) == 1) ? CHAR_CR : 8'($urandom_range(11, 255)));
         end
      endcase
      repeat ($urandom_range(4, 16)) push_byte(8'($urandom_range(0, 255)));
      wait_idle();

      $display("run covered %0d head bytes with %0d header lines, %0d token transactions",
               n_bytes, n_lines, n_checked);
      $display("head closed by %s, %0d mismatches", end_kind, errors);
      if (errors == 0) begin
         $display("** http_request_head_tokenizer: PASSED **");
      end else begin
         $display("** http_request_head_tokenizer: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d bytes unsent and %0d tokens outstanding",
               head_bytes.size(), token_q.size());
      $display("** http_request_head_tokenizer: FAILED **");
      $finish;
   end

endmodule
